FILE: rtl/ivt_pkg.sv
// ivt_pkg: shared types, codes and key helper for the identifier value table.
// Used by ivt_cell and identifier_value_table; depends on nothing else.
`timescale 1ns / 1ps

package ivt_pkg;

    localparam int KEY_W  = 64;
    localparam int DATA_W = 32;

    // Request kinds carried in tuser on the input side
    localparam logic REQ_ASSIGN = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // Search token handed from cell to cell
    typedef struct packed {
        logic              active;
        logic              found;
        logic              appended;
        logic [DATA_W-1:0] value;
    } ivt_token_t;

    // Keep bytes up to the first zero byte and at most nchars bytes, MSB first
    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] raw,
                                                       input int unsigned nchars);
        logic [KEY_W-1:0] norm;
        logic             live;
        norm = '0;
        live = 1'b1;
        for (int i = 0; i < KEY_W / 8; i++)
        begin
            if (i >= nchars || raw[KEY_W-1-8*i -: 8] == 8'h00)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                norm[KEY_W-1-8*i -: 8] = raw[KEY_W-1-8*i -: 8];
            end
        end
        return norm;
    endfunction

endpackage

FILE: rtl/identifier_value_table.sv
// identifier_value_table: symbol table built as a chain of TABLE_DEPTH slot cells.
// An empty key skips the cell chain and goes straight to the pending result.
// One item at a time: a new item is taken only after its token has left the cell chain and its result has moved on.
// A new item is taken while the previous result still waits on the output side.
// Reset clears the fill count and all control; slot contents are not cleared.
// Depends on ivt_pkg and ivt_cell.
`timescale 1ns / 1ps

module identifier_value_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_CHARS   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // key [63:0], data_in [95:64]
    input  logic [0:0]  s_tuser,   // req_type [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data_out [31:0]
    output logic [1:0]  m_tuser    // status [1:0]
);
    import ivt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_BUSY, S_HOLD} state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              req_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] data_reg;
    ivt_token_t        start_reg;
    logic [DATA_W-1:0] res_data_reg;
    logic [1:0]        res_status_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [1:0]        out_status_reg;

    ivt_token_t        chain [0:TABLE_DEPTH];
    ivt_token_t        done_tok;
    logic [KEY_W-1:0]  norm_key;
    logic              in_xfer;
    logic              out_free;

    assign norm_key = normalize_key(s_tdata[KEY_W-1:0], KEY_CHARS);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign done_tok = chain[TABLE_DEPTH];
    assign chain[0] = start_reg;

    // Row of slot cells
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        ivt_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .token_in  (chain[g]),
            .token_out (chain[g+1]),
            .req_type  (req_reg),
            .key       (key_reg),
            .data      (data_reg),
            .count     (count_reg)
        );
    end

    // Latch the request, held steady while the token walks the chain
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg  <= s_tuser[0];
            key_reg  <= norm_key;
            data_reg <= s_tdata[KEY_W +: DATA_W];
        end
    end

    // Sequencer, fill count, pending result and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            start_reg      <= '0;
            res_data_reg   <= '0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            // Launch a token for every nonempty key taken in
            start_reg.active <= in_xfer && (norm_key != '0);
            if (out_valid_reg && m_tready && state_reg != S_HOLD)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (norm_key == '0)
                        begin
                            res_data_reg   <= '0;
                            res_status_reg <= ST_EMPTY;
                            state_reg      <= S_HOLD;
                        end
                        else
                        begin
                            state_reg <= S_BUSY;
                        end
                    end
                end
                S_BUSY:
                begin
                    if (done_tok.active)
                    begin
                        if (req_reg == REQ_ASSIGN)
                        begin
                            res_data_reg   <= '0;
                            res_status_reg <= done_tok.found ? ST_OK : ST_FULL;
                            if (done_tok.appended)
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            res_data_reg   <= done_tok.found ? done_tok.value : '0;
                            res_status_reg <= done_tok.found ? ST_OK : ST_MISSING;
                        end
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_data_reg   <= res_data_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    // Fill count never passes the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // A token leaves the chain only while the sequencer waits for it
    a_token_exit: assert property (@(posedge clk) disable iff (!rst_n)
        done_tok.active |-> state_reg == S_BUSY)
        else $error("token left the chain outside a search");

    // A missed assign is reported full only when every slot is filled
    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done_tok.active && req_reg == REQ_ASSIGN && !done_tok.found)
        |-> count_reg == CNT_W'(TABLE_DEPTH))
        else $error("assign missed on a table with free slots");

    // An append happens only with a free slot left
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (done_tok.active && done_tok.appended) |-> count_reg < CNT_W'(TABLE_DEPTH))
        else $error("append on a full table");

endmodule

FILE: rtl/ivt_cell.sv
// ivt_cell: one table slot holding a key and a value, with a registered token stage.
// Depends on ivt_pkg for the token type and request codes.
`timescale 1ns / 1ps

module ivt_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ivt_pkg::ivt_token_t        token_in,
    output ivt_pkg::ivt_token_t        token_out,
    input  logic                       req_type,
    input  logic [ivt_pkg::KEY_W-1:0]  key,
    input  logic [ivt_pkg::DATA_W-1:0] data,
    input  logic [CNT_W-1:0]           count
);
    import ivt_pkg::*;

    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] val_reg;
    ivt_token_t        token_reg;
    ivt_token_t        token_next;
    logic              filled;
    logic              searching;
    logic              match;
    logic              append;

    // Slot state relative to the fill count
    assign filled    = CNT_W'(IDX) < count;
    assign searching = token_in.active && !token_in.found;
    assign match     = searching && filled && (key_reg == key);
    assign append    = searching && (req_type == REQ_ASSIGN) && (count == CNT_W'(IDX));

    // Update the token for the next cell
    always_comb
    begin
        token_next          = token_in;
        token_next.found    = token_in.found | match | append;
        token_next.appended = token_in.appended | append;
        if (match && req_type == REQ_READ)
        begin
            token_next.value = val_reg;
        end
    end

    // Advance the token one cell per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= '0;
        end
        else
        begin
            token_reg <= token_next;
        end
    end

    // Store key and value on append, value alone on update
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            key_reg <= key;
            val_reg <= data;
        end
        else if (match && req_type == REQ_ASSIGN)
        begin
            val_reg <= data;
        end
    end

    assign token_out = token_reg;

endmodule

FILE: test/identifier_value_table_tb.sv
// identifier_value_table_tb: self-checking testbench for the identifier value table.
// Predicts each result with its own symbol table copy; depends on ivt_pkg and the RTL.
`timescale 1ns / 1ps

module identifier_value_table_tb;

    import ivt_pkg::*;

    localparam int DEPTH        = 64;
    localparam int POOL_SIZE    = 96;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
    } lookup_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;   // key [63:0], data_in [95:64]
    logic [0:0]  s_tuser  = '0;   // req_type [0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // data_out [31:0]
    logic [1:0]  m_tuser;         // status [1:0]

    // Predicted symbol table contents
    logic [63:0] entry_keys [DEPTH];
    logic [31:0] entry_vals [DEPTH];
    int          entry_count = 0;

    // Identifiers reused by the random part so that reads hit and updates land
    logic [63:0] name_pool [POOL_SIZE];

    lookup_result_t expected_results [$];
    lookup_result_t head_result;
    int             mismatches  = 0;
    int             cycle_count = 0;
    bit             idle_on     = 1'b1;

    identifier_value_table #(
        .TABLE_DEPTH (DEPTH),
        .KEY_CHARS   (8)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Cut the identifier at its first zero byte
    function automatic logic [63:0] trim_key(input logic [63:0] raw);
        logic [63:0] name;
        name = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (raw[63-8*i -: 8] == 8'h00)
            begin
                break;
            end
            name[63-8*i -: 8] = raw[63-8*i -: 8];
        end
        return name;
    endfunction

    function automatic int lookup_slot(input logic [63:0] name);
        for (int i = 0; i < entry_count; i++)
        begin
            if (entry_keys[i] == name)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    // Apply one request to the predicted table and return its result
    function automatic lookup_result_t apply_request(input logic req, input logic [63:0] raw,
                                                     input logic [31:0] value);
        lookup_result_t r;
        logic [63:0]    name;
        int             slot;
        name     = trim_key(raw);
        slot     = lookup_slot(name);
        r.value  = '0;
        r.status = ST_OK;
        if (name == '0)
        begin
            r.status = ST_EMPTY;
        end
        else if (req == REQ_ASSIGN)
        begin
            if (slot >= 0)
            begin
                entry_vals[slot] = value;
            end
            else if (entry_count >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                entry_keys[entry_count] = name;
                entry_vals[entry_count] = value;
                entry_count++;
            end
        end
        else if (slot >= 0)
        begin
            r.value = entry_vals[slot];
        end
        else
        begin
            r.status = ST_MISSING;
        end
        return r;
    endfunction

    // Build a clean identifier of len nonzero bytes
    function automatic logic [63:0] make_name(input int len);
        logic [63:0] name;
        name = '0;
        for (int i = 0; i < len; i++)
        begin
            name[63-8*i -: 8] = 8'($urandom_range(1, 255));
        end
        return name;
    endfunction

    // Fill the bytes behind the terminator with junk half the time
    function automatic logic [63:0] dress_key(input logic [63:0] name);
        logic [63:0] raw;
        bit          past_end;
        raw      = name;
        past_end = 1'b0;
        if ($urandom_range(0, 1) == 0)
        begin
            return raw;
        end
        for (int i = 0; i < 8; i++)
        begin
            if (past_end)
            begin
                raw[63-8*i -: 8] = 8'($urandom);
            end
            if (name[63-8*i -: 8] == 8'h00)
            begin
                past_end = 1'b1;
            end
        end
        return raw;
    endfunction

    function automatic logic [63:0] unused_name();
        logic [63:0] name;
        do
        begin
            name = make_name($urandom_range(1, 8));
        end
        while (lookup_slot(name) >= 0);
        return name;
    endfunction

    // Present one request and record its expected result once transferred
    task automatic send_item(input logic req, input logic [63:0] raw, input logic [31:0] value);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {value, raw};
        s_tuser  <= req;
        do @(posedge clk); while (!s_tready);
        expected_results.push_back(apply_request(req, raw, value));
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        // read on an empty table misses
        send_item(REQ_READ, 64'h4100_0000_0000_0000, 32'h0);
        // empty identifiers, clean and with junk behind the terminator
        send_item(REQ_ASSIGN, 64'h0, 32'h1234_5678);
        send_item(REQ_READ, 64'h00FF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_item(REQ_ASSIGN, 64'h0012_3456_789A_BCDE, 32'h0);
        // eight-byte identifiers at both ends of the byte range
        send_item(REQ_ASSIGN, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
        send_item(REQ_READ, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_item(REQ_ASSIGN, 64'h0101_0101_0101_0101, 32'h8000_0000);
        send_item(REQ_READ, 64'h0101_0101_0101_0101, 32'hFFFF_FFFF);
        // single-byte identifier, then overwrite it
        send_item(REQ_ASSIGN, 64'h7800_0000_0000_0000, 32'h8000_0000);
        send_item(REQ_READ, 64'h7800_0000_0000_0000, 32'h5555_5555);
        send_item(REQ_ASSIGN, 64'h7800_0000_0000_0000, 32'hFFFF_FFFF);
        send_item(REQ_READ, 64'h7800_0000_0000_0000, 32'h0);
        // bytes behind the terminator take no part in storing or matching
        send_item(REQ_ASSIGN, 64'h6162_00AB_CDEF_1234, 32'h0000_0000);
        send_item(REQ_READ, 64'h6162_0000_0000_0000, 32'h0);
        send_item(REQ_READ, 64'h6162_0077_7777_7777, 32'hAAAA_AAAA);
        // a longer identifier with the same prefix is a different entry
        send_item(REQ_READ, 64'h6162_6300_0000_0000, 32'h0);
        send_item(REQ_ASSIGN, 64'h6162_6300_FF00_FF00, 32'h0000_0001);
        send_item(REQ_READ, 64'h6162_6300_0000_0000, 32'h0);
        send_item(REQ_READ, 64'h6162_0000_0000_0000, 32'h0);
    endtask

    // Mixed traffic: pool hits, fresh misses, empty keys and raw noise
    task automatic random_requests(input int count);
        int          pick;
        logic        req;
        logic [63:0] raw;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            req  = ($urandom_range(0, 1) == 0) ? REQ_ASSIGN : REQ_READ;
            if (pick < 40)
            begin
                req = REQ_ASSIGN;
                raw = dress_key(name_pool[$urandom_range(0, POOL_SIZE - 1)]);
            end
            else if (pick < 80)
            begin
                req = REQ_READ;
                raw = dress_key(name_pool[$urandom_range(0, POOL_SIZE - 1)]);
            end
            else if (pick < 88)
            begin
                raw = dress_key(make_name($urandom_range(1, 8)));
            end
            else if (pick < 94)
            begin
                raw = {8'h00, 56'({$urandom, $urandom})};
            end
            else
            begin
                raw = {$urandom, $urandom};
            end
            send_item(req, raw, $urandom);
        end
    endtask

    task automatic test_random_fill();
        // distinct identifiers, more than the table holds
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            bit dup;
            do
            begin
                name_pool[i] = make_name($urandom_range(1, 8));
                dup = 1'b0;
                for (int j = 0; j < i; j++)
                begin
                    if (name_pool[j] == name_pool[i])
                    begin
                        dup = 1'b1;
                    end
                end
            end
            while (dup);
        end
        random_requests(480);
    endtask

    task automatic test_full_table();
        logic [63:0] name;
        // top up any free slots
        while (entry_count < DEPTH)
        begin
            send_item(REQ_ASSIGN, unused_name(), $urandom);
        end
        // new identifier is refused, existing ones still update and read, an empty key still reports empty
        name = unused_name();
        send_item(REQ_ASSIGN, dress_key(name), $urandom);
        send_item(REQ_READ, name, $urandom);
        send_item(REQ_ASSIGN, entry_keys[0], 32'h8000_0000);
        send_item(REQ_READ, entry_keys[0], 32'h0);
        send_item(REQ_ASSIGN, entry_keys[DEPTH-1], 32'h7FFF_FFFF);
        send_item(REQ_READ, dress_key(entry_keys[DEPTH-1]), 32'h0);
        send_item(REQ_ASSIGN, 64'h0, 32'hFFFF_FFFF);
    endtask

    task automatic finish_run();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    endtask

    // Receiver: stall in random bursts while idling is on
    initial
    begin
        int stall;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 9);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: data_out %h status %0d", m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                head_result = expected_results.pop_front();
                if (m_tdata !== head_result.value)
                begin
                    $error("data_out mismatch: expected %h, actual %h",
                           head_result.value, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== head_result.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           head_result.status, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_fill();
        wait_drained();
        test_full_table();
        random_requests(400);
        // last stretch runs without idling on either side
        idle_on = 1'b0;
        random_requests(150);
        finish_run();
    end

endmodule
